/* rtl/core/brbf_pkg.sv */
// ----------------------------------------------------------------------------
// brbf_pkg
// Shared types and constants for the byte ring block FIFO.
// ----------------------------------------------------------------------------
package brbf_pkg;

  localparam int BYTE_W = 8;
  localparam int LANES  = 8;
  localparam int LANE_W = 3;
  localparam int LEN_W  = 4;
  localparam int DATA_W = LANES * BYTE_W;
  localparam int CAP_W  = 11;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef logic [LANES-1:0][BYTE_W-1:0] lane_bytes_t;

  // what stage 2 carries to the pop aligner
  typedef struct packed {
    logic              ok;
    logic              pop;
    logic [LEN_W-1:0]  len;
    logic [LANE_W-1:0] rot;
  } pop_meta_t;

endpackage

/* rtl/core/brbf_in_if.sv */
// ----------------------------------------------------------------------------
// brbf_in_if
// Request channel: push or pop of one byte block.
// ----------------------------------------------------------------------------
interface brbf_in_if;
  import brbf_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [LEN_W-1:0]  block_length;
  logic [DATA_W-1:0] push_data;

  modport source (output valid, output mode, output block_length, output push_data,
                  input ready);
  modport sink   (input valid, input mode, input block_length, input push_data,
                  output ready);

endinterface

/* rtl/core/brbf_out_if.sv */
// ----------------------------------------------------------------------------
// brbf_out_if
// Result channel: one result per request.
// ----------------------------------------------------------------------------
interface brbf_out_if;
  import brbf_pkg::*;

  logic              valid;
  logic              ready;
  logic              accepted;
  logic [LEN_W-1:0]  moved_count;
  logic [DATA_W-1:0] pop_data;

  modport source (output valid, output accepted, output moved_count, output pop_data,
                  input ready);
  modport sink   (input valid, input accepted, input moved_count, input pop_data,
                  output ready);

endinterface

/* rtl/core/brbf_lane_ram.sv */
// ----------------------------------------------------------------------------
// brbf_lane_ram
// One byte lane of the ring store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module brbf_lane_ram #(
  parameter int ROWS = 128,
  parameter int RW   = 7
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [RW-1:0]              waddr,
  input  logic [brbf_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [RW-1:0]              raddr,
  output logic [brbf_pkg::BYTE_W-1:0] rdata
);
  import brbf_pkg::*;

  logic [BYTE_W-1:0] mem [ROWS];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/brbf_pop_align.sv */
// ----------------------------------------------------------------------------
// brbf_pop_align
// Rotates the lane read data into block order and masks unused bytes.
// ----------------------------------------------------------------------------
module brbf_pop_align (
  input  brbf_pkg::pop_meta_t         meta,
  input  brbf_pkg::lane_bytes_t       lane_data,
  output logic                        accepted,
  output logic [brbf_pkg::LEN_W-1:0]  moved_count,
  output logic [brbf_pkg::DATA_W-1:0] pop_data
);
  import brbf_pkg::*;

  always_comb begin
    logic [LANE_W-1:0] lane;
    pop_data = '0;
    for (int i = 0; i < LANES; i++) begin
      lane = LANE_W'(meta.rot + LANE_W'(i));
      if (meta.ok && meta.pop && (LEN_W'(i) < meta.len)) begin
        pop_data[i*BYTE_W +: BYTE_W] = lane_data[lane];
      end
    end
  end

  assign accepted    = meta.ok;
  assign moved_count = meta.ok ? meta.len : '0;

endmodule

/* rtl/core/byte_ring_block_fifo.sv */
// ----------------------------------------------------------------------------
// byte_ring_block_fifo
// Circular byte buffer with all-or-nothing block push and pop.
// ----------------------------------------------------------------------------
// Takes one request per cycle and returns one result per request, in order,
// through three register stages (request register, lane RAM read register,
// result register); output stalls fill pipeline bubbles before in_ch.ready
// drops. Bytes live in eight byte-wide lane RAMs of ceil(DEPTH/8) rows each,
// so a block of up to eight bytes is one write or one read per lane, with all
// lanes accessed together. The capacity register only limits the fill count;
// a capacity write empties the buffer and must be issued while the block
// is idle.
module byte_ring_block_fifo #(
  parameter int DEPTH     = 1024,
  parameter int MAX_BLOCK = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  brbf_in_if.sink                    in_ch,
  brbf_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [brbf_pkg::CAP_W-1:0] cfg_data
);
  import brbf_pkg::*;

  localparam int ROWS   = (DEPTH + LANES - 1) / LANES;
  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W0 = $clog2(DEPTH + 1);
  localparam int SW     = (CNT_W0 > CAP_W) ? CNT_W0 : CAP_W;

  // stage 1: request register
  logic              s1_valid_r;
  logic              s1_mode_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic [DATA_W-1:0] s1_data_r;

  // ring state
  logic [SW-1:0]     size_r;
  logic [SW-1:0]     fill_r;
  logic [SW-1:0]     fill_nxt;
  logic [RW-1:0]     wr_row_r, wr_row_nxt;
  logic [LANE_W-1:0] wr_lane_r, wr_lane_nxt;
  logic [RW-1:0]     rd_row_r, rd_row_nxt;
  logic [LANE_W-1:0] rd_lane_r, rd_lane_nxt;

  // stage 2 and result register
  logic              s2_valid_r;
  pop_meta_t         s2_meta_r;
  logic              out_valid_r;
  logic              out_acc_r;
  logic [LEN_W-1:0]  out_cnt_r;
  logic [DATA_W-1:0] out_data_r;

  logic              s3_ld, s2_ld, s1_go;
  logic              len_ok, fits, enough, s1_ok, s1_push;
  logic [SW-1:0]     cfg_size;
  lane_bytes_t       lane_rd;
  logic              al_acc;
  logic [LEN_W-1:0]  al_cnt;
  logic [DATA_W-1:0] al_data;

  assign s3_ld       = !out_valid_r || out_ch.ready;
  assign s2_ld       = !s2_valid_r || s3_ld;
  assign s1_go       = s1_valid_r && s2_ld;
  assign in_ch.ready = !s1_valid_r || s2_ld;

  always_comb begin
    cfg_size = SW'(cfg_data);
    if (cfg_size == '0) begin
      cfg_size = SW'(1);
    end else if (cfg_size > SW'(DEPTH)) begin
      cfg_size = SW'(DEPTH);
    end
  end

  // admission check
  assign len_ok  = ({28'd0, s1_len_r} <= 32'(MAX_BLOCK));
  assign fits    = ({1'b0, fill_r} + (SW+1)'(s1_len_r)) <= {1'b0, size_r};
  assign enough  = fill_r >= SW'(s1_len_r);
  assign s1_push = (s1_mode_r == MODE_PUSH);
  assign s1_ok   = len_ok && (s1_push ? fits : enough);

  // pointer advance by one block: lane carry bumps the row, which wraps
  always_comb begin
    logic [LANE_W:0] wsum, rsum;
    wsum        = {1'b0, wr_lane_r} + (LANE_W+1)'(s1_len_r);
    rsum        = {1'b0, rd_lane_r} + (LANE_W+1)'(s1_len_r);
    wr_lane_nxt = wsum[LANE_W-1:0];
    rd_lane_nxt = rsum[LANE_W-1:0];
    wr_row_nxt  = wr_row_r;
    rd_row_nxt  = rd_row_r;
    if (wsum[LANE_W]) begin
      wr_row_nxt = (wr_row_r == RW'(ROWS - 1)) ? '0 : RW'(wr_row_r + RW'(1));
    end
    if (rsum[LANE_W]) begin
      rd_row_nxt = (rd_row_r == RW'(ROWS - 1)) ? '0 : RW'(rd_row_r + RW'(1));
    end
    fill_nxt = s1_push ? SW'(fill_r + SW'(s1_len_r)) : SW'(fill_r - SW'(s1_len_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      size_r     <= SW'(DEPTH);
      fill_r     <= '0;
      wr_row_r   <= '0;
      wr_lane_r  <= '0;
      rd_row_r   <= '0;
      rd_lane_r  <= '0;
      s2_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        size_r    <= cfg_size;
        fill_r    <= '0;
        wr_row_r  <= '0;
        wr_lane_r <= '0;
        rd_row_r  <= '0;
        rd_lane_r <= '0;
      end else if (s1_go && s1_ok) begin
        fill_r <= fill_nxt;
        if (s1_push) begin
          wr_row_r  <= wr_row_nxt;
          wr_lane_r <= wr_lane_nxt;
        end else begin
          rd_row_r  <= rd_row_nxt;
          rd_lane_r <= rd_lane_nxt;
        end
      end

      if (s2_ld) begin
        s2_valid_r <= s1_go;
      end
      if (s3_ld) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_mode_r <= in_ch.mode;
      s1_len_r  <= in_ch.block_length;
      s1_data_r <= in_ch.push_data;
    end
    if (s1_go) begin
      s2_meta_r.ok  <= s1_ok;
      s2_meta_r.pop <= !s1_push;
      s2_meta_r.len <= s1_len_r;
      s2_meta_r.rot <= rd_lane_r;
    end
    if (s2_valid_r && s3_ld) begin
      out_acc_r  <= al_acc;
      out_cnt_r  <= al_cnt;
      out_data_r <= al_data;
    end
  end

  // lane RAMs: byte i of a block sits in lane (pointer lane + i) mod 8
  for (genvar b = 0; b < LANES; b++) begin : g_lane
    logic [LANE_W-1:0] woff;
    logic              wsel;
    logic [RW-1:0]     waddr, raddr;

    assign woff  = LANE_W'(LANE_W'(b) - wr_lane_r);
    assign wsel  = ({1'b0, woff} < s1_len_r);
    assign waddr = (LANE_W'(b) >= wr_lane_r) ? wr_row_r :
                   ((wr_row_r == RW'(ROWS - 1)) ? '0 : RW'(wr_row_r + RW'(1)));
    assign raddr = (LANE_W'(b) >= rd_lane_r) ? rd_row_r :
                   ((rd_row_r == RW'(ROWS - 1)) ? '0 : RW'(rd_row_r + RW'(1)));

    brbf_lane_ram #(
      .ROWS (ROWS),
      .RW   (RW)
    ) u_ram (
      .clk   (clk),
      .we    (s1_go && s1_ok && s1_push && wsel),
      .waddr (waddr),
      .wdata (s1_data_r[woff*BYTE_W +: BYTE_W]),
      .re    (s1_go),
      .raddr (raddr),
      .rdata (lane_rd[b])
    );
  end

  brbf_pop_align u_align (
    .meta        (s2_meta_r),
    .lane_data   (lane_rd),
    .accepted    (al_acc),
    .moved_count (al_cnt),
    .pop_data    (al_data)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.accepted    = out_acc_r;
  assign out_ch.moved_count = out_cnt_r;
  assign out_ch.pop_data    = out_data_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= size_r)
    else $error("fill count above ring size");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (rd_row_r == wr_row_r && rd_lane_r == wr_lane_r))
    else $error("empty ring with split pointers");

  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_ok && s1_push && !cfg_we) |=>
      (fill_r == SW'($past(fill_r) + SW'($past(s1_len_r)))))
    else $error("push did not grow fill count by block length");

  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_acc_r) |-> (out_cnt_r == '0 && out_data_r == '0))
    else $error("refused request moved data");
`endif

endmodule
